FILE: rtl/brl_pkg.sv
// Shared constants and types for the line rasteriser.
// No dependencies; every other source file uses this package.
`default_nettype none

package brl_pkg;

  // Default coordinate width of the rasteriser
  localparam int unsigned COORD_BITS_DEF = 11;

  // Request mode codes
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

endpackage

`default_nettype wire

FILE: rtl/brl_if.sv
// Valid/ready channel interfaces of the line rasteriser: requests in,
// classified commands between front and back, pixels out. Uses brl_pkg.
`default_nettype none

interface brl_cmd_if #(
  parameter int unsigned CB = brl_pkg::COORD_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic          mode;
  logic [CB-1:0] x_start;
  logic [CB-1:0] y_start;
  logic [CB-1:0] x_end;
  logic [CB-1:0] y_end;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface brl_q_if #(
  parameter int unsigned CB = brl_pkg::COORD_BITS_DEF
);
  typedef struct packed {
    logic          is_load;
    logic          steep;
    logic          minor_down;
    logic [CB-1:0] major_pos;
    logic [CB-1:0] minor_pos;
    logic [CB-1:0] major_end;
    logic [CB-1:0] major_delta;
    logic [CB-1:0] minor_delta;
  } op_t;

  logic valid;
  logic ready;
  op_t  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface brl_pix_if #(
  parameter int unsigned CB = brl_pkg::COORD_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CB-1:0] pixel_x;
  logic [CB-1:0] pixel_y;
  logic          last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

FILE: rtl/bresenham_line_rasterizer.sv
// Bresenham line rasteriser: a load request sets up a line, each step
// request on an active line yields one pixel. An accepted step request
// passes the command queue and then the output register.
// Throughput: one request per cycle unless pix_o stalls; error update is combinational.
// Reset (rst_ni low, asynchronous) empties the queue and drops any line.
// Uses brl_pkg, brl_if, brl_front, brl_queue and brl_back.
`default_nettype none

module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brl_cmd_if.sink   cmd_i,
  brl_pix_if.source pix_o
);
  import brl_pkg::*;

  brl_q_if #(.CB(COORD_BITS)) front_q ();
  brl_q_if #(.CB(COORD_BITS)) q_back ();

  brl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .cmd_i (cmd_i),
    .op_o  (front_q)
  );

  brl_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (front_q),
    .op_o   (q_back)
  );

  brl_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (q_back),
    .pix_o  (pix_o)
  );

endmodule

`default_nettype wire

FILE: rtl/brl_front.sv
// Front end: accepts requests and classifies load requests into a
// major/minor line description. Depends on brl_pkg and brl_if.
`default_nettype none

module brl_front #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  brl_cmd_if.sink  cmd_i,
  brl_q_if.source  op_o
);
  import brl_pkg::*;

  logic [COORD_BITS-1:0] dx, dy;
  logic                  steep;
  logic [COORD_BITS-1:0] ma, na, mb, nb;
  logic [COORD_BITS-1:0] m_lo, n_lo, m_hi, n_hi;
  logic                  is_load;

  assign is_load = (cmd_i.mode == MODE_LOAD);

  // Measure both spans and pick the major axis
  assign dx    = (cmd_i.x_start > cmd_i.x_end) ? cmd_i.x_start - cmd_i.x_end
                                               : cmd_i.x_end - cmd_i.x_start;
  assign dy    = (cmd_i.y_start > cmd_i.y_end) ? cmd_i.y_start - cmd_i.y_end
                                               : cmd_i.y_end - cmd_i.y_start;
  assign steep = dx < dy;

  always_comb begin
    if (steep) begin
      ma = cmd_i.y_start; na = cmd_i.x_start;
      mb = cmd_i.y_end;   nb = cmd_i.x_end;
    end else begin
      ma = cmd_i.x_start; na = cmd_i.y_start;
      mb = cmd_i.x_end;   nb = cmd_i.y_end;
    end
  end

  // Order the endpoints so the major coordinate rises
  always_comb begin
    if (mb < ma) begin
      m_lo = mb; n_lo = nb; m_hi = ma; n_hi = na;
    end else begin
      m_lo = ma; n_lo = na; m_hi = mb; n_hi = nb;
    end
  end

  // Build the queued command; step requests carry no geometry
  always_comb begin
    op_o.data             = '0;
    op_o.data.is_load     = is_load;
    if (is_load) begin
      op_o.data.steep       = steep;
      op_o.data.major_pos   = m_lo;
      op_o.data.minor_pos   = n_lo;
      op_o.data.major_end   = m_hi;
      op_o.data.major_delta = m_hi - m_lo;
      op_o.data.minor_delta = (n_hi < n_lo) ? n_lo - n_hi : n_hi - n_lo;
      op_o.data.minor_down  = n_hi < n_lo;
    end
  end

  assign op_o.valid  = cmd_i.valid;
  assign cmd_i.ready = op_o.ready;

endmodule

`default_nettype wire

FILE: rtl/brl_queue.sv
// Two-entry command queue between front and back end.
// Depends on brl_pkg and brl_if.
`default_nettype none

module brl_queue #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brl_q_if.sink     op_i,
  brl_q_if.source   op_o
);
  import brl_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned OpW   = 3 + 5 * COORD_BITS;

  logic [OpW-1:0]  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign op_i.ready = (count_q != CntW'(Depth));
  assign op_o.valid = (count_q != '0);
  assign op_o.data  = mem_q[rd_ptr_q];
  assign push       = op_i.valid && op_i.ready;
  assign pop        = op_o.valid && op_o.ready;

  // Store incoming commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op_i.data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count missed a push");

endmodule

`default_nettype wire

FILE: rtl/brl_back.sv
// Back end: holds the active line, steps it one pixel per step command and
// registers each pixel in an output stage. Depends on brl_pkg and brl_if.
`default_nettype none

module brl_back #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brl_q_if.sink     op_i,
  brl_pix_if.source pix_o
);
  import brl_pkg::*;

  localparam int unsigned EW = COORD_BITS + 2;

  logic                  active_q, active_d;
  logic                  steep_q;
  logic                  minor_down_q;
  logic [COORD_BITS-1:0] major_pos_q, major_pos_d;
  logic [COORD_BITS-1:0] minor_pos_q, minor_pos_d;
  logic [COORD_BITS-1:0] major_end_q;
  logic [COORD_BITS-1:0] major_delta_q;
  logic [COORD_BITS-1:0] minor_delta_q;
  logic signed [EW-1:0]  err_q, err_d;
  logic signed [EW-1:0]  err_acc;
  logic signed [EW:0]    err_dbl;
  logic                  advance;
  logic                  last;

  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic                  last_q;

  logic                  out_free;
  logic                  pop;
  logic                  is_load;
  logic                  emit;

  assign is_load    = op_i.data.is_load;
  assign out_free   = !out_valid_q || pix_o.ready;
  assign op_i.ready = is_load || !active_q || out_free;
  assign pop        = op_i.valid && op_i.ready;
  assign emit       = pop && !is_load && active_q;

  // Error update for one step along the major axis
  assign last    = (major_pos_q == major_end_q);
  assign err_acc = err_q + $signed({2'b00, minor_delta_q});
  assign err_dbl = {err_acc, 1'b0};
  assign advance = err_dbl > $signed({3'b000, major_delta_q});

  always_comb begin
    active_d    = active_q;
    major_pos_d = major_pos_q;
    minor_pos_d = minor_pos_q;
    err_d       = err_q;
    if (pop && is_load) begin
      active_d    = 1'b1;
      major_pos_d = op_i.data.major_pos;
      minor_pos_d = op_i.data.minor_pos;
      err_d       = '0;
    end else if (emit) begin
      err_d = err_acc;
      if (advance) begin
        minor_pos_d = minor_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
        err_d       = err_acc - $signed({2'b00, major_delta_q});
      end
      if (last) begin
        active_d = 1'b0;
      end else begin
        major_pos_d = major_pos_q + 1'b1;
      end
    end
  end

  // Hold the output stage until taken
  assign out_valid_d = emit || (out_valid_q && !pix_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      major_pos_q <= '0;
      minor_pos_q <= '0;
      err_q       <= '0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      major_pos_q <= major_pos_d;
      minor_pos_q <= minor_pos_d;
      err_q       <= err_d;
    end
  end

  // Latch line geometry on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steep_q       <= 1'b0;
      minor_down_q  <= 1'b0;
      major_end_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
    end else if (pop && is_load) begin
      steep_q       <= op_i.data.steep;
      minor_down_q  <= op_i.data.minor_down;
      major_end_q   <= op_i.data.major_end;
      major_delta_q <= op_i.data.major_delta;
      minor_delta_q <= op_i.data.minor_delta;
    end
  end

  // Register the pixel, swapped back to x/y order for steep lines
  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= steep_q ? minor_pos_q : major_pos_q;
      py_q   <= steep_q ? major_pos_q : minor_pos_q;
      last_q <= last;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pixel_x    = px_q;
  assign pix_o.pixel_y    = py_q;
  assign pix_o.last_pixel = last_q;

  a_load_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && is_load) |=> (active_q && err_q == '0))
    else $error("load did not arm the line");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> !active_q)
    else $error("line still active after last pixel");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("stepped pixel not presented");

endmodule

`default_nettype wire

FILE: test/tb_bresenham_line_rasterizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Bresenham line rasteriser: a built-in line
// predictor checks every pixel. Depends on brl_pkg, brl_if and the rasteriser RTL.

module tb_bresenham_line_rasterizer;
  import brl_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int COORD_MAX  = (1 << CB) - 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_GAP    = 6;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni;

  brl_cmd_if #(.CB(CB)) cmd_bus ();
  brl_pix_if #(.CB(CB)) pix_bus ();

  bresenham_line_rasterizer #(.COORD_BITS(CB)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .pix_o  (pix_bus)
  );

  // Line state of the predictor
  logic               ln_active;
  logic               ln_steep;
  coord_t             ln_major_pos;
  coord_t             ln_minor_pos;
  coord_t             ln_major_end;
  coord_t             ln_major_delta;
  coord_t             ln_minor_delta;
  logic               ln_minor_down;
  logic signed [CB+1:0] ln_error;

  pixel_t pixel_q[$];

  bit gaps_on = 1'b1;
  int n_requests, n_loads, n_pixels, n_last, n_fail, idle_cycles;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic coord_t coord_dist(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  // Advance the predicted line by one request; returns 1 if the request had any effect
  function automatic bit predict_line(mode_e m, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    coord_t ma, na, mb, nb, t;
    pixel_t px;
    logic   is_last;
    if (m == MODE_LOAD) begin
      ln_steep = coord_dist(xs, xe) < coord_dist(ys, ye);
      if (ln_steep) begin
        ma = ys; na = xs; mb = ye; nb = xe;
      end else begin
        ma = xs; na = ys; mb = xe; nb = ye;
      end
      // order the endpoints so that the major coordinate rises
      if (mb < ma) begin
        t = ma; ma = mb; mb = t;
        t = na; na = nb; nb = t;
      end
      ln_major_pos   = ma;
      ln_minor_pos   = na;
      ln_major_end   = mb;
      ln_major_delta = mb - ma;
      ln_minor_delta = coord_dist(na, nb);
      ln_minor_down  = nb < na;
      ln_error       = '0;
      ln_active      = 1'b1;
      n_loads++;
      return 1'b1;
    end
    if (!ln_active) return 1'b0;
    is_last = (ln_major_pos == ln_major_end);
    px.x    = ln_steep ? ln_minor_pos : ln_major_pos;
    px.y    = ln_steep ? ln_major_pos : ln_minor_pos;
    px.last = is_last;
    pixel_q.push_back(px);
    // step the minor axis once twice the error passes the major delta
    ln_error = ln_error + $signed({2'b00, ln_minor_delta});
    if (2 * int'(ln_error) > int'(ln_major_delta)) begin
      ln_minor_pos = ln_minor_down ? ln_minor_pos - 1'b1 : ln_minor_pos + 1'b1;
      ln_error     = ln_error - $signed({2'b00, ln_major_delta});
    end
    if (is_last) ln_active = 1'b0;
    else ln_major_pos = ln_major_pos + 1'b1;
    return 1'b1;
  endfunction

  // Present one request, hold it until accepted, then update the prediction
  task automatic send_request(mode_e m, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.mode    <= m;
    cmd_bus.x_start <= xs;
    cmd_bus.y_start <= ys;
    cmd_bus.x_end   <= xe;
    cmd_bus.y_end   <= ye;
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (predict_line(m, xs, ys, xe, ye)) n_requests++;
  endtask

  task automatic load_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    send_request(MODE_LOAD, xs, ys, xe, ye);
  endtask

  // Step with junk in the coordinate fields, which must be ignored
  task automatic step_pixels(int count);
    repeat (count)
      send_request(MODE_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Steps with no line loaded yield nothing
  task automatic test_step_without_line();
    step_pixels(2);
  endtask

  task automatic test_single_point();
    load_line(11'd1234, 11'd567, 11'd1234, 11'd567);
    step_pixels(2);
  endtask

  // Reversed horizontal run ending on the top coordinate
  task automatic test_reversed_run();
    load_line(11'd2047, 11'd0, 11'd2044, 11'd0);
    step_pixels(4);
  endtask

  task automatic test_steep_descent();
    load_line(11'd2, 11'd6, 11'd0, 11'd2);
    step_pixels(5);
  endtask

  // Equal deltas keep x as the major axis
  task automatic test_equal_deltas();
    load_line(11'd0, 11'd0, 11'd2, 11'd2);
    step_pixels(3);
  endtask

  // A full-range diagonal, abandoned early by the next load
  task automatic test_reload_while_active();
    load_line(11'd0, 11'd2047, 11'd2047, 11'd0);
    step_pixels(2);
    load_line(11'd2047, 11'd2047, 11'd2047, 11'd2047);
    step_pixels(1);
  endtask

  function automatic coord_t offset_coord(coord_t s, int d, bit down);
    if (down ? (int'(s) - d >= 0) : (int'(s) + d > COORD_MAX)) return coord_t'(int'(s) - d);
    return coord_t'(int'(s) + d);
  endfunction

  // Mostly complete short lines with random content, plus long lines, single points and noise
  task automatic test_random_lines(int n_target);
    int     base, kind, dx, dy, pixels, steps;
    coord_t xs, ys, xe, ye;
    base = n_requests;
    while (n_requests - base < n_target) begin
      kind    = $urandom_range(0, 9);
      gaps_on = ($urandom_range(0, 3) != 0);
      xs      = rand_coord();
      ys      = rand_coord();
      if (kind <= 6) begin
        dx = $urandom_range(0, 12);
        dy = $urandom_range(0, 12);
        xe = offset_coord(xs, dx, 1'($urandom_range(0, 1)));
        ye = offset_coord(ys, dy, 1'($urandom_range(0, 1)));
        pixels = ((dx > dy) ? dx : dy) + 1;
        if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, pixels - 1);
        else steps = pixels + $urandom_range(0, 2);
        load_line(xs, ys, xe, ye);
        step_pixels(steps);
      end else if (kind == 7) begin
        load_line(xs, ys, rand_coord(), rand_coord());
        step_pixels($urandom_range(5, 30));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4))
          send_request(mode_e'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord());
      end else begin
        load_line(xs, ys, xs, ys);
        step_pixels($urandom_range(1, 2));
      end
    end
  endtask

  // Accept pixels with random stalls and check each against the oldest prediction
  initial begin
    int     stall;
    pixel_t want;
    pix_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        pix_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pix_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!pix_bus.valid);
      if (pixel_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected pixel x=%0d y=%0d last=%0d", pix_bus.pixel_x,
                   pix_bus.pixel_y, pix_bus.last_pixel);
      end else begin
        want = pixel_q.pop_front();
        n_pixels++;
        if (want.last) n_last++;
        if (pix_bus.pixel_x !== want.x || pix_bus.pixel_y !== want.y ||
            pix_bus.last_pixel !== want.last) begin
          n_fail++;
          if (n_fail <= 10)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                     want.x, want.y, want.last, pix_bus.pixel_x, pix_bus.pixel_y,
                     pix_bus.last_pixel);
        end
      end
    end
  end

  // Abort when neither side has completed a handshake for too long
  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cmd_bus.valid   <= 1'b0;
    cmd_bus.mode    <= MODE_LOAD;
    cmd_bus.x_start <= '0;
    cmd_bus.y_start <= '0;
    cmd_bus.x_end   <= '0;
    cmd_bus.y_end   <= '0;
    ln_active       = 1'b0;
    ln_steep        = 1'b0;
    ln_major_pos    = '0;
    ln_minor_pos    = '0;
    ln_major_end    = '0;
    ln_major_delta  = '0;
    ln_minor_delta  = '0;
    ln_minor_down   = 1'b0;
    ln_error        = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_step_without_line();
    test_single_point();
    test_reversed_run();
    test_steep_descent();
    test_equal_deltas();
    test_reload_while_active();
    test_random_lines(500);

    // drain outstanding pixels, then allow for the pipeline latency
    cmd_bus.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d effective requests (%0d line loads), %0d pixels checked,",
             n_requests, n_loads, n_pixels);
    $display("%0d of them line ends; %0d failures.", n_last, n_fail);
    if (n_fail == 0 && pixel_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: bresenham_line_rasterizer.f
rtl/brl_pkg.sv
rtl/brl_if.sv
rtl/brl_front.sv
rtl/brl_queue.sv
rtl/brl_back.sv
rtl/bresenham_line_rasterizer.sv
test/tb_bresenham_line_rasterizer.sv
